[src/phe_pkg.sv]
// Shared types, constants and saturation helper for the Horner polynomial evaluator.
`default_nettype none

package phe_pkg;

    // Word format: signed fixed point, fraction width set at the top level
    localparam int WORD_W        = 32;
    localparam int NUM_COEF      = 6;
    localparam int CNT_W         = 3;
    localparam int IDX_W         = 3;
    localparam int MAX_TERMS_DEF = 6;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic signed [2*WORD_W-1:0] t_wide;

    // Saturated word plus overflow mark
    typedef struct packed {
        t_word val;
        logic  ovf;
    } t_sat;

    // Configuration register map
    typedef enum logic [IDX_W-1:0] {
        REG_TERM_COUNT,
        REG_COEF_0,
        REG_COEF_1,
        REG_COEF_2,
        REG_COEF_3,
        REG_COEF_4,
        REG_COEF_5
    } t_cfg_idx;

    // Clamp a wide signed value into one word
    function automatic t_sat sat_word(input t_wide v);
        t_sat res;
        if ((v[2*WORD_W-1:WORD_W-1] == '0) || (v[2*WORD_W-1:WORD_W-1] == '1)) begin
            res.val = v[WORD_W-1:0];
            res.ovf = 1'b0;
        end else begin
            res.val = v[2*WORD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                    : {1'b0, {(WORD_W-1){1'b1}}};
            res.ovf = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/polynomial_horner_eval.sv]
// Horner polynomial evaluator: value and first derivative, signed fixed point.
//
// Usage:
//   Slave stream takes one evaluation point x per word (tdata = x).
//   Master stream returns one word per point: tdata = {slope, poly},
//   tuser = {saturated, empty_error}.
//   Config channel writes term_count (index 0) and coef_0..coef_5 (1..6);
//   it is always ready. Write it only while no words are in flight.
// Pipeline: one multiply stage and one shift/saturate/add stage per
//   Horner step; with MAX_TERMS of 1 a single step of each is kept.
// Throughput: one point per cycle while the output is not blocked; poly
//   and slope chains run side by side, two 32x32 multipliers per step.
// Stall: each stage holds its word when the one after it is full and
//   blocked, so bubbles close up and a stalled result loses nothing;
//   s_axis_tready drops only when every stage is occupied.
// Reset: pipeline emptied, term_count = 1, all coefficients = 0.
`default_nettype none

module polynomial_horner_eval import phe_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Evaluation points
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [WORD_W-1:0]   i_s_axis_tdata,  // [31:0] x_value
    // Results
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [2*WORD_W-1:0]      o_m_axis_tdata,  // [31:0] poly_value, [63:32] slope_value
    output logic [1:0]               o_m_axis_tuser,  // [0] empty_error, [1] saturated
    // Configuration writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [IDX_W-1:0]    i_cfg_index,
    input  wire logic [WORD_W-1:0]   i_cfg_data
);

    localparam int STEPS  = (MAX_TERMS > 1) ? MAX_TERMS - 1 : 1;
    localparam int NSLOT  = STEPS + 1;
    localparam int NSTAGE = 2 * STEPS;

    // Configuration registers
    logic [CNT_W-1:0] r_term_count;
    t_word            r_coef [NUM_COEF];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= CNT_W'(1);
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_TERM_COUNT: r_term_count <= i_cfg_data[CNT_W-1:0];
                REG_COEF_0:     r_coef[0]    <= i_cfg_data;
                REG_COEF_1:     r_coef[1]    <= i_cfg_data;
                REG_COEF_2:     r_coef[2]    <= i_cfg_data;
                REG_COEF_3:     r_coef[3]    <= i_cfg_data;
                REG_COEF_4:     r_coef[4]    <= i_cfg_data;
                REG_COEF_5:     r_coef[5]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Coefficients in use; unused high terms read as zero, which leaves
    // Horner's result and the saturation flag unchanged
    t_word w_coef [NSLOT];

    for (genvar j = 0; j < NSLOT; j++) begin : g_coef
        if ((j < MAX_TERMS) && (j < NUM_COEF)) begin : g_used
            assign w_coef[j] = (j < int'(r_term_count)) ? r_coef[j] : '0;
        end else begin : g_zero
            assign w_coef[j] = '0;
        end
    end

    // Derivative terms (m+1)*c_(m+1), constant multiply and clamp
    t_word            w_scaled [STEPS];
    logic [STEPS-1:0] w_scaled_ovf;

    for (genvar m = 0; m < STEPS; m++) begin : g_scale
        t_sat n_scl;
        assign n_scl           = sat_word(t_wide'(w_coef[m+1]) * t_wide'(m + 1));
        assign w_scaled[m]     = n_scl.val;
        assign w_scaled_ovf[m] = n_scl.ovf;
    end

    // Stage valid bits and per-stage advance
    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE-1:0] w_en;

    for (genvar s = 0; s < NSTAGE; s++) begin : g_ctl
        if (s == NSTAGE - 1) begin : g_last
            assign w_en[s] = !r_v[s] || i_m_axis_tready;
        end else begin : g_mid
            assign w_en[s] = !r_v[s] || w_en[s+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_v[s] <= (s == 0) ? i_s_axis_tvalid : r_v[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign o_s_axis_tready = w_en[0];

    // Multiply stage outputs
    t_word r_mx [STEPS];
    t_wide r_mp [STEPS];
    t_wide r_ms [STEPS];
    logic  r_mf [STEPS];
    // Add stage outputs
    t_word r_ax [STEPS];
    t_word r_ap [STEPS];
    t_word r_as [STEPS];
    logic  r_af [STEPS];

    // One Horner step per k: multiply, then floor shift, clamp, add, clamp
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        t_word w_x;
        t_word w_p;
        t_word w_s;
        logic  w_f;
        t_sat  n_pprod;
        t_sat  n_psum;
        t_sat  n_sprod;
        t_sat  n_ssum;

        if (k == 0) begin : g_head
            assign w_x = t_word'(i_s_axis_tdata);
            assign w_p = w_coef[STEPS];
            assign w_s = '0;
            assign w_f = 1'b0;
        end else begin : g_chain
            assign w_x = r_ax[k-1];
            assign w_p = r_ap[k-1];
            assign w_s = r_as[k-1];
            assign w_f = r_af[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_en[2*k]) begin
                r_mx[k] <= w_x;
                r_mp[k] <= t_wide'(w_x) * t_wide'(w_p);
                r_ms[k] <= t_wide'(w_x) * t_wide'(w_s);
                r_mf[k] <= w_f;
            end
        end

        assign n_pprod = sat_word(r_mp[k] >>> FRAC_BITS);
        assign n_psum  = sat_word(t_wide'(n_pprod.val) + t_wide'(w_coef[STEPS-1-k]));
        assign n_sprod = sat_word(r_ms[k] >>> FRAC_BITS);
        assign n_ssum  = sat_word(t_wide'(n_sprod.val) + t_wide'(w_scaled[STEPS-1-k]));

        always_ff @(posedge i_clk) begin
            if (w_en[2*k+1]) begin
                r_ax[k] <= r_mx[k];
                r_ap[k] <= n_psum.val;
                r_as[k] <= n_ssum.val;
                r_af[k] <= r_mf[k] | n_pprod.ovf | n_psum.ovf | n_sprod.ovf | n_ssum.ovf;
            end
        end
    end

    // Result word; scaled-term flag and empty flag come from static config
    assign o_m_axis_tvalid   = r_v[NSTAGE-1];
    assign o_m_axis_tdata    = {r_as[STEPS-1], r_ap[STEPS-1]};
    assign o_m_axis_tuser[0] = (r_term_count == '0);
    assign o_m_axis_tuser[1] = r_af[STEPS-1] | (|w_scaled_ovf);

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for polynomial_horner_eval: predicted value, slope and flags per point.
module tb_top;
    import phe_pkg::*;

    localparam int SETTLE_CYCLES  = 2 * (MAX_TERMS_DEF - 1) + 6;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_POINTS   = 140;
    localparam int PRESSURE_PHASE = 6;
    localparam int HOLD_CYCLES    = 300;

    localparam t_word WORD_HI = 32'sh7FFF_FFFF;
    localparam t_word WORD_LO = 32'sh8000_0000;
    localparam t_word ONE_Q16 = 32'sh0001_0000;
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE = 3'd7;  // no register behind it

    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483647 - 64'sd1;

    // One result word, split into its fields
    typedef struct packed {
        t_word poly;
        t_word slope;
        logic  empty_err;
        logic  sat;
    } t_eval;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic s_valid = 1'b0;
    logic [WORD_W-1:0] s_data = '0;
    logic m_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    wire logic s_ready;
    wire logic m_valid;
    wire logic [2*WORD_W-1:0] m_data;
    wire logic [1:0] m_user;
    wire logic cfg_ready;

    // Stimulus control
    t_word pending_points[$];
    t_eval expected_evals[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off = 1'b0;
    int mismatch_count = 0;

    // Shadow of the register file
    logic [CNT_W-1:0] model_terms = 3'd1;
    t_word model_coef [NUM_COEF] = '{default: '0};

    t_word corner_x [6] = '{32'sh0, 32'sh1, -32'sh1, WORD_HI, WORD_LO, ONE_Q16};

    polynomial_horner_eval uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Clamp to one signed word, marking overflow
    function automatic longint clamp_word(input longint v, inout bit ovf);
        if (v > SAT_MAX) begin
            ovf = 1'b1;
            return SAT_MAX;
        end
        if (v < SAT_MIN) begin
            ovf = 1'b1;
            return SAT_MIN;
        end
        return v;
    endfunction

    // acc' = sat(sat(floor(x*acc / 2^F)) + c)
    function automatic longint horner_step(input longint acc, input longint x,
                                           input longint c, inout bit ovf);
        longint prod;
        prod = clamp_word((x * acc) >>> FRAC_BITS_DEF, ovf);
        return clamp_word(prod + c, ovf);
    endfunction

    // Value and derivative at x under the current register settings
    function automatic t_eval eval_point(input t_word x);
        t_eval res;
        longint xl, poly_acc, slope_acc;
        longint scaled [NUM_COEF];
        int n;
        bit ovf;
        res = '0;
        ovf = 1'b0;
        xl = x;
        slope_acc = 0;
        n = (model_terms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : model_terms;
        if (n == 0) begin
            res.empty_err = 1'b1;
            return res;
        end
        poly_acc = model_coef[n-1];
        for (int j = n - 1; j > 0; j--)
            poly_acc = horner_step(poly_acc, xl, model_coef[j-1], ovf);
        // derivative terms i*c_i
        for (int i = 1; i < n; i++)
            scaled[i-1] = clamp_word(i * longint'(model_coef[i]), ovf);
        if (n > 1) begin
            slope_acc = scaled[n-2];
            for (int j = n - 2; j > 0; j--)
                slope_acc = horner_step(slope_acc, xl, scaled[j-1], ovf);
        end
        res.poly  = t_word'(poly_acc);
        res.slope = t_word'(slope_acc);
        res.sat   = ovf;
        return res;
    endfunction

    // Mostly small coefficients so that some polynomials stay unsaturated
    function automatic t_word rand_coef();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? WORD_HI : WORD_LO;
            1, 2: return t_word'($urandom());
            default: return t_word'($urandom_range(32'h80000)) - 32'sh40000;
        endcase
    endfunction

    function automatic t_word rand_point();
        case ($urandom_range(9))
            0: return corner_x[$urandom_range(5)];
            1, 2: return t_word'($urandom());
            default: return t_word'($urandom_range(32'h40000)) - 32'sh20000;
        endcase
    endfunction

    // Register write; the caller lowers cfg_valid after its last write
    task automatic write_reg(input logic [IDX_W-1:0] idx, input t_word val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TERM_COUNT: model_terms = val[CNT_W-1:0];
            REG_COEF_0, REG_COEF_1, REG_COEF_2,
            REG_COEF_3, REG_COEF_4, REG_COEF_5: model_coef[idx - REG_COEF_0] = val;
            default: ;  // unmapped: ignored
        endcase
    endtask

    task automatic write_all(input int terms, input t_word c0, input t_word c1,
                             input t_word c2, input t_word c3, input t_word c4,
                             input t_word c5);
        write_reg(REG_TERM_COUNT, t_word'(terms));
        write_reg(REG_COEF_0, c0);
        write_reg(REG_COEF_1, c1);
        write_reg(REG_COEF_2, c2);
        write_reg(REG_COEF_3, c3);
        write_reg(REG_COEF_4, c4);
        write_reg(REG_COEF_5, c5);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every point is sent and every result is back, then let the pipe settle
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_points.size() != 0 || s_valid || expected_evals.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string what, input t_word want, input t_word got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Point driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_valid && s_ready)
                expected_evals.push_back(eval_point(s_data));
            if (!s_valid || s_ready) begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_points.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk) begin : result_check
        t_eval want;
        if (rst_n) begin
            if (m_valid && m_ready) begin
                if (expected_evals.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h/%b",
                             $time, m_data, m_user);
                    mismatch_count++;
                end else begin
                    want = expected_evals.pop_front();
                    check_field("poly_value", want.poly, m_data[WORD_W-1:0]);
                    check_field("slope_value", want.slope, m_data[2*WORD_W-1:WORD_W]);
                    check_field("empty_error", t_word'(want.empty_err), t_word'(m_user[0]));
                    check_field("saturated", t_word'(want.sat), t_word'(m_user[1]));
                end
            end
            m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus sequence
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: one term, all coefficients zero
        foreach (corner_x[i]) pending_points.push_back(corner_x[i]);
        wait_idle();

        // Empty polynomial; a write to the spare index must change nothing
        write_reg(REG_TERM_COUNT, 32'sh0);
        write_reg(CFG_IDX_SPARE, 32'sh1234_5676);
        cfg_valid <= 1'b0;
        pending_points.push_back(WORD_HI);
        pending_points.push_back(WORD_LO);
        wait_idle();

        // p(x) = x, slope 1.0
        write_all(2, 32'sh0, ONE_Q16, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
        pending_points.push_back(32'sh1);
        pending_points.push_back(WORD_HI);
        pending_points.push_back(WORD_LO);
        wait_idle();

        // Term count 7 behaves as six; positive full scale saturates
        write_all(7, WORD_HI, WORD_HI, WORD_HI, WORD_HI, WORD_HI, WORD_HI);
        pending_points.push_back(ONE_Q16);
        pending_points.push_back(-ONE_Q16);
        pending_points.push_back(WORD_LO);
        wait_idle();

        // Negative full scale, six terms
        write_all(6, WORD_LO, WORD_LO, WORD_LO, WORD_LO, WORD_LO, WORD_LO);
        pending_points.push_back(32'sh0002_0000);
        pending_points.push_back(WORD_HI);
        wait_idle();

        // Single term: constant value, zero slope, upper terms ignored
        write_all(1, WORD_LO, WORD_HI, WORD_HI, WORD_HI, WORD_HI, WORD_HI);
        pending_points.push_back(32'sh5);
        pending_points.push_back(WORD_HI);
        wait_idle();

        // Small quadratic, no saturation
        write_all(3, 32'sh0001_8000, -32'sh0002_0000, 32'sh0000_4000, 32'sh0, 32'sh0, 32'sh0);
        pending_points.push_back(-32'sh0001_8000);
        pending_points.push_back(32'sh0000_4000);
        wait_idle();

        // Random phases over the idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_all((ph < 8) ? ph : $urandom_range(7), rand_coef(), rand_coef(),
                      rand_coef(), rand_coef(), rand_coef(), rand_coef());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (ph == PRESSURE_PHASE) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                hold_off <= 1'b1;
            end
            repeat (PHASE_POINTS) pending_points.push_back(rand_point());
            // long output stall while points keep coming
            if (ph == PRESSURE_PHASE) begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
